@@ hdl/bde_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce event engine package
// Shared types and constants for the debounce sequencer and its time compare.
// ----------------------------------------------------------------------------
package bde_pkg;

   localparam int MAX_BUTTONS = 16;
   localparam int IDX_W       = $clog2(MAX_BUTTONS);

   // Configuration register indexes.
   localparam logic [2:0] CSR_ACTIVE_LEVEL  = 3'd0;
   localparam logic [2:0] CSR_INVERT_MASK   = 3'd1;
   localparam logic [2:0] CSR_SELECTOR_MASK = 3'd2;
   localparam logic [2:0] CSR_REPEAT_MASK   = 3'd3;
   localparam logic [2:0] CSR_BUTTON_COUNT  = 3'd4;
   localparam logic [2:0] CSR_DEBOUNCE_MS   = 3'd5;
   localparam logic [2:0] CSR_REPEAT_MS     = 3'd6;
   localparam logic [2:0] CSR_POLL_INTERVAL = 3'd7;

   typedef enum logic [2:0] {
      EVT_PRESS        = 3'd0,
      EVT_RELEASE      = 3'd1,
      EVT_REPEAT       = 3'd2,
      EVT_SELECTOR_ON  = 3'd3,
      EVT_SELECTOR_OFF = 3'd4,
      EVT_ALL_OFF      = 3'd5
   } evt_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DEBOUNCE,
      ST_PRESS,
      ST_RELEASE,
      ST_REPEAT,
      ST_SELECT,
      ST_ALL_OFF,
      ST_FLUSH
   } seq_state_type;

   // Operands of the shared elapsed-time compare.
   typedef struct packed {
      logic [31:0] now;
      logic [31:0] base;
      logic [15:0] limit;
   } cmp_req_type;

endpackage

@@ hdl/bde_if.sv @@
// ----------------------------------------------------------------------------
// Button debounce event engine channels
// Poll channel and event channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bde_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pin_levels;
   logic [31:0] time_ms;
   modport source (output valid, output pin_levels, output time_ms, input ready);
   modport sink   (input valid, input pin_levels, input time_ms, output ready);
endinterface

interface bde_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [4:0]  button;
   logic [15:0] stable_buttons;
   logic        last;
   modport source (output valid, output event_kind, output button,
                   output stable_buttons, output last, input ready);
   modport sink   (input valid, input event_kind, input button,
                   input stable_buttons, input last, output ready);
endinterface

@@ hdl/bde_time_cmp.sv @@
// ----------------------------------------------------------------------------
// Elapsed time compare
// Wrapping 32-bit elapsed time against a 16-bit limit, shared by the interval check, debounce and repeat.
// ----------------------------------------------------------------------------
module bde_time_cmp (
   input  bde_pkg::cmp_req_type cmp_req,
   output logic                 expired
);
   import bde_pkg::*;

   logic [31:0] elapsed;

   always_comb begin
      elapsed = cmp_req.now - cmp_req.base;
      expired = (elapsed >= {16'd0, cmp_req.limit});
   end

endmodule

@@ hdl/button_debounce_event_engine.sv @@
// ----------------------------------------------------------------------------
// Button debounce event engine
// Debounces up to sixteen buttons per poll and reports press, release,
// auto-repeat and selector events over a valid/ready event channel.
// ----------------------------------------------------------------------------
// Usage: each item on req_ch is one poll (pin levels and a millisecond time).
// The block takes one poll at a time; req_ch.ready is high only while the
// sequencer is idle. A poll closer than poll_interval to the last processed
// poll is dropped with no events. Otherwise one shared elapsed-time
// comparator is stepped over the buttons in five passes (debounce, press,
// release, repeat, selector), one button per cycle while rsp_ch does not
// stall an event, then an all-selectors-off step and a flush step. Events
// leave in order on rsp_ch; the last one of a poll has last set. One event
// is held back until the next is known so that last can be marked. If the
// receiver stalls, the sequencer waits on the event it cannot place and no
// state moves. Reset (synchronous) clears the sequencer, debounce and output
// state and loads the register defaults: 16 buttons, 50 ms debounce, 200 ms
// repeat. Configuration is written through csr_we/csr_index/csr_wdata; the
// user must write it only while idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module button_debounce_event_engine (
   input  logic        clock,
   input  logic        reset,
   bde_req_if.sink     req_ch,
   bde_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bde_pkg::*;

   // Configuration registers.
   logic        act_ff;
   logic [15:0] inv_ff, selm_ff, repm_ff, deb_ff, repms_ff, poll_ff;
   logic [4:0]  cnt_ff;

   // Sequencer and poll state.
   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      pins_ff, raw_ff;
   logic [31:0]      now_ff, lastpoll_ff;
   logic [15:0]      stable_ff, pend_ff, ptgt_ff, held_ff, snap_ff;
   logic [31:0]      start_ff [MAX_BUTTONS];
   logic [31:0]      rpt_ff   [MAX_BUTTONS];

   // One event waits here until we know whether it ends the poll.
   logic         hold_valid_ff;
   evt_kind_type hold_kind_ff;
   logic [4:0]   hold_btn_ff;

   // Output register.
   logic         rsp_valid_ff, rsp_last_ff;
   evt_kind_type rsp_kind_ff;
   logic [4:0]   rsp_btn_ff;
   logic [15:0]  rsp_stable_ff;

   // Step decode.
   cmp_req_type  cmp_req;
   logic         expired;
   logic [4:0]   count_eff;
   logic         last_idx;
   logic         raw_b, stb_b, pend_b, tgt_b, held_b, sel_b, rep_b;
   logic         differ, restart;
   logic [15:0]  cur_sel, changes;
   logic         emit, adv, out_free, push, push_last;
   evt_kind_type emit_kind;
   logic [4:0]   emit_btn;

   bde_time_cmp u_cmp (
      .cmp_req (cmp_req),
      .expired (expired)
   );

   always_comb begin
      count_eff = (cnt_ff > 5'(MAX_BUTTONS)) ? 5'(MAX_BUTTONS) : cnt_ff;
      last_idx  = ({1'b0, idx_ff} == (count_eff - 5'd1));
      raw_b     = raw_ff[idx_ff];
      stb_b     = stable_ff[idx_ff];
      pend_b    = pend_ff[idx_ff];
      tgt_b     = ptgt_ff[idx_ff];
      held_b    = held_ff[idx_ff];
      sel_b     = selm_ff[idx_ff];
      rep_b     = repm_ff[idx_ff];
      differ    = raw_b ^ stb_b;
      // The timer restarts only for a new target; an unchanged target keeps it.
      restart   = differ && (!pend_b || (tgt_b != raw_b));
      cur_sel   = stable_ff & selm_ff;
      changes   = cur_sel ^ snap_ff;
      out_free  = !rsp_valid_ff || rsp_ch.ready;
   end

   // Operand selection for the shared comparator and event decode.
   always_comb begin
      cmp_req.now   = now_ff;
      cmp_req.base  = lastpoll_ff;
      cmp_req.limit = poll_ff;
      emit          = 1'b0;
      emit_kind     = EVT_PRESS;
      emit_btn      = 5'({1'b0, idx_ff} + 5'd1);
      unique case (state_ff)
         ST_DEBOUNCE: begin
            cmp_req.base  = restart ? now_ff : start_ff[idx_ff];
            cmp_req.limit = deb_ff;
         end
         ST_PRESS: begin
            emit      = stb_b && !held_b && !sel_b;
            emit_kind = EVT_PRESS;
         end
         ST_RELEASE: begin
            emit      = held_b && !stb_b && !sel_b;
            emit_kind = EVT_RELEASE;
         end
         ST_REPEAT: begin
            cmp_req.base  = rpt_ff[idx_ff];
            cmp_req.limit = repms_ff;
            emit          = held_b && stb_b && rep_b && expired;
            emit_kind     = EVT_REPEAT;
         end
         ST_SELECT: begin
            emit      = changes[idx_ff];
            emit_kind = cur_sel[idx_ff] ? EVT_SELECTOR_ON : EVT_SELECTOR_OFF;
         end
         ST_ALL_OFF: begin
            emit      = (changes != 16'd0) && (cur_sel == 16'd0);
            emit_kind = EVT_ALL_OFF;
            emit_btn  = 5'd0;
         end
         default: begin
         end
      endcase
      // A new event can be taken if the slot is empty or its old event moves on.
      adv       = !emit || !hold_valid_ff || out_free;
      push      = emit && hold_valid_ff && out_free;
      push_last = (state_ff == ST_FLUSH) && hold_valid_ff && out_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_ch.valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            idx_in = '0;
            if (!expired) begin
               state_in = ST_IDLE;
            end else if (count_eff == 5'd0) begin
               state_in = ST_ALL_OFF;
            end else begin
               state_in = ST_DEBOUNCE;
            end
         end
         ST_DEBOUNCE, ST_PRESS, ST_RELEASE, ST_REPEAT, ST_SELECT: begin
            if (adv) begin
               if (last_idx) begin
                  idx_in = '0;
                  unique case (state_ff)
                     ST_DEBOUNCE: state_in = ST_PRESS;
                     ST_PRESS:    state_in = ST_RELEASE;
                     ST_RELEASE:  state_in = ST_REPEAT;
                     ST_REPEAT:   state_in = ST_SELECT;
                     default:     state_in = ST_ALL_OFF;
                  endcase
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_ALL_OFF: begin
            if (adv) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         inv_ff   <= 16'd0;
         selm_ff  <= 16'd0;
         repm_ff  <= 16'd0;
         cnt_ff   <= 5'd16;
         deb_ff   <= 16'd50;
         repms_ff <= 16'd200;
         poll_ff  <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVEL:  act_ff   <= csr_wdata[0];
            CSR_INVERT_MASK:   inv_ff   <= csr_wdata;
            CSR_SELECTOR_MASK: selm_ff  <= csr_wdata;
            CSR_REPEAT_MASK:   repm_ff  <= csr_wdata;
            CSR_BUTTON_COUNT:  cnt_ff   <= csr_wdata[4:0];
            CSR_DEBOUNCE_MS:   deb_ff   <= csr_wdata;
            CSR_REPEAT_MS:     repms_ff <= csr_wdata;
            CSR_POLL_INTERVAL: poll_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Poll capture needs no reset.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_ch.valid) begin
         pins_ff <= req_ch.pin_levels;
         now_ff  <= req_ch.time_ms;
      end
      if (state_ff == ST_CHECK) begin
         raw_ff <= ~(pins_ff ^ ({16{act_ff}} ^ inv_ff));
      end
   end

   // Debounce and event state.
   always_ff @(posedge clock) begin
      if (reset) begin
         lastpoll_ff <= 32'd0;
         stable_ff   <= 16'd0;
         pend_ff     <= 16'd0;
         ptgt_ff     <= 16'd0;
         held_ff     <= 16'd0;
         snap_ff     <= 16'd0;
         for (int i = 0; i < MAX_BUTTONS; i++) begin
            start_ff[i] <= 32'd0;
            rpt_ff[i]   <= 32'd0;
         end
      end else begin
         unique case (state_ff)
            ST_CHECK: begin
               if (expired) begin
                  lastpoll_ff <= now_ff;
               end
            end
            ST_DEBOUNCE: begin
               if (!differ) begin
                  pend_ff[idx_ff] <= 1'b0;
               end else begin
                  if (restart) begin
                     ptgt_ff[idx_ff]  <= raw_b;
                     start_ff[idx_ff] <= now_ff;
                  end
                  // Commit once the change has lasted the debounce time.
                  if (expired) begin
                     pend_ff[idx_ff]   <= 1'b0;
                     stable_ff[idx_ff] <= restart ? raw_b : tgt_b;
                  end else begin
                     pend_ff[idx_ff] <= 1'b1;
                  end
               end
            end
            ST_PRESS: begin
               if (emit && adv) begin
                  held_ff[idx_ff] <= 1'b1;
                  rpt_ff[idx_ff]  <= now_ff;
               end
            end
            ST_RELEASE: begin
               if (emit && adv) begin
                  held_ff[idx_ff] <= 1'b0;
                  rpt_ff[idx_ff]  <= 32'd0;
               end
            end
            ST_REPEAT: begin
               if (emit && adv) begin
                  rpt_ff[idx_ff] <= now_ff;
               end
            end
            ST_ALL_OFF: begin
               if (adv) begin
                  snap_ff <= cur_sel;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Holding slot and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (emit && adv) begin
            hold_valid_ff <= 1'b1;
         end else if (push_last) begin
            hold_valid_ff <= 1'b0;
         end
         if (push || push_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit && adv) begin
         hold_kind_ff <= emit_kind;
         hold_btn_ff  <= emit_btn;
      end
      if (push || push_last) begin
         rsp_kind_ff   <= hold_kind_ff;
         rsp_btn_ff    <= hold_btn_ff;
         rsp_stable_ff <= stable_ff;
         rsp_last_ff   <= push_last;
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.event_kind     = rsp_kind_ff;
   assign rsp_ch.button         = rsp_btn_ff;
   assign rsp_ch.stable_buttons = rsp_stable_ff;
   assign rsp_ch.last           = rsp_last_ff;

`ifndef SYNTHESIS
   // The holding slot is always drained before the next poll is taken.
   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("event left in holding slot while idle");

   // An accepted poll always goes to the interval check next.
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_CHECK))
      else $error("accepted poll not checked");

   // Only the all-selectors-off event carries button zero.
   a_button_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == EVT_ALL_OFF) == (rsp_btn_ff == 5'd0)))
      else $error("button number does not match event kind");

   // A stalled step moves no sequencer position.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && state_ff != ST_IDLE) |=> $stable(idx_ff) && $stable(state_ff))
      else $error("sequencer advanced while stalled");
`endif

endmodule

@@ sim/button_debounce_event_engine_tb.sv @@
// ----------------------------------------------------------------------------
// Button debounce event engine testbench
// Sends polls through the request channel and compares every event against
// a cycle-free prediction of debounce, press, release, repeat and selector
// behavior, under random idling on both sides and a long receiver stall.
// ----------------------------------------------------------------------------
module button_debounce_event_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bde_pkg::*;

   typedef struct {
      evt_kind_type kind;
      logic [4:0]   button;
      logic [15:0]  pattern;
      logic         last;
   } button_event_type;

   logic clock;
   logic reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   bde_req_if req_ch();
   bde_rsp_if rsp_ch();

   button_debounce_event_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the configuration registers.
   logic        cfg_active;
   logic [15:0] cfg_invert, cfg_selector, cfg_repeat;
   logic [4:0]  cfg_count;
   logic [15:0] cfg_debounce, cfg_repeat_ms, cfg_interval;

   // Shadow copy of the debounce state.
   logic [15:0] stable_q, pending_q, target_q, held_q, sel_seen_q;
   logic [31:0] change_at [16];
   logic [31:0] repeat_at [16];
   logic [31:0] last_poll_q;

   button_event_type expected_events[$];

   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  jitter_on = 1;        // random idling on both channels
   int  stall_request = 0;    // receiver hold-off length, picked up by the ready process
   logic [31:0] clock_ms = 0; // time base of the stimulus

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Adds one event to the local list of a poll, with the current pattern.
   function automatic void add_event(ref button_event_type evs[$],
                                     input evt_kind_type k, input int btn);
      button_event_type e;
      e.kind = k;
      e.button = btn[4:0];
      e.pattern = stable_q;
      e.last = 1'b0;
      evs.push_back(e);
   endfunction

   // Works out the events of one accepted poll and updates the shadow state.
   function automatic void predict_poll(input logic [15:0] pins, input logic [31:0] now_ms);
      button_event_type evs[$];
      logic [15:0] polarity, raw, cur, changes, bit_m;
      int count;
      count = (cfg_count > 16) ? 16 : cfg_count;
      if (now_ms - last_poll_q < {16'd0, cfg_interval}) return;
      last_poll_q = now_ms;
      polarity = (cfg_active ? 16'hFFFF : 16'h0000) ^ cfg_invert;
      raw = ~(pins ^ polarity);
      for (int i = 0; i < count; i++) begin
         bit_m = 16'd1 << i;
         if (((raw ^ stable_q) & bit_m) != 0) begin
            if ((pending_q & bit_m) == 0 || ((target_q ^ raw) & bit_m) != 0) begin
               target_q = (target_q & ~bit_m) | (raw & bit_m);
               change_at[i] = now_ms;
               pending_q |= bit_m;
            end
         end else begin
            pending_q &= ~bit_m;
         end
      end
      for (int i = 0; i < count; i++) begin
         bit_m = 16'd1 << i;
         if ((pending_q & bit_m) != 0 && now_ms - change_at[i] >= {16'd0, cfg_debounce}) begin
            pending_q &= ~bit_m;
            stable_q = (stable_q & ~bit_m) | (target_q & bit_m);
         end
      end
      for (int i = 0; i < count; i++) begin
         bit_m = 16'd1 << i;
         if ((stable_q & ~held_q & bit_m) != 0 && (cfg_selector & bit_m) == 0) begin
            held_q |= bit_m;
            repeat_at[i] = now_ms;
            add_event(evs, EVT_PRESS, i + 1);
         end
      end
      for (int i = 0; i < count; i++) begin
         bit_m = 16'd1 << i;
         if ((held_q & ~stable_q & bit_m) != 0 && (cfg_selector & bit_m) == 0) begin
            held_q &= ~bit_m;
            repeat_at[i] = 0;
            add_event(evs, EVT_RELEASE, i + 1);
         end
      end
      for (int i = 0; i < count; i++) begin
         bit_m = 16'd1 << i;
         if ((held_q & stable_q & cfg_repeat & bit_m) != 0 &&
             now_ms - repeat_at[i] >= {16'd0, cfg_repeat_ms}) begin
            repeat_at[i] = now_ms;
            add_event(evs, EVT_REPEAT, i + 1);
         end
      end
      cur = stable_q & cfg_selector;
      if (cur != sel_seen_q) begin
         changes = cur ^ sel_seen_q;
         for (int i = 0; i < count; i++) begin
            bit_m = 16'd1 << i;
            if ((changes & bit_m) != 0)
               add_event(evs, ((cur & bit_m) != 0) ? EVT_SELECTOR_ON : EVT_SELECTOR_OFF, i + 1);
         end
         if (cur == 0) add_event(evs, EVT_ALL_OFF, 0);
         sel_seen_q = cur;
      end
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[k]) expected_events.push_back(evs[k]);
   endfunction

   // Pin levels that make the given buttons read as pressed.
   function automatic logic [15:0] pins_for(input logic [15:0] pressed);
      return ~pressed ^ ((cfg_active ? 16'hFFFF : 16'h0000) ^ cfg_invert);
   endfunction

   // Register writes are made only while the block is idle.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_ACTIVE_LEVEL:  cfg_active = value[0];
         CSR_INVERT_MASK:   cfg_invert = value;
         CSR_SELECTOR_MASK: cfg_selector = value;
         CSR_REPEAT_MASK:   cfg_repeat = value;
         CSR_BUTTON_COUNT:  cfg_count = value[4:0];
         CSR_DEBOUNCE_MS:   cfg_debounce = value;
         CSR_REPEAT_MS:     cfg_repeat_ms = value;
         default:           cfg_interval = value;
      endcase
   endtask

   // Sends one poll; the expectation is formed at the edge that accepts it.
   task automatic send_poll(input logic [15:0] pins, input logic [31:0] now_ms);
      if (jitter_on && $urandom_range(99) < 27) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.pin_levels = pins;
      req_ch.time_ms = now_ms;
      do @(posedge clock); while (!req_ch.ready);
      predict_poll(pins, now_ms);
      @(negedge clock);
   endtask

   // Polls with the given buttons pressed, after a step of the time base.
   task automatic poll_after(input logic [31:0] step_ms, input logic [15:0] pressed);
      clock_ms += step_ms;
      send_poll(pins_for(pressed), clock_ms);
   endtask

   // Waits until every expected event has come, then for longer than one
   // poll takes, since a dropped or silent poll can still be in flight.
   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   // Receiver side: random stalls, or one long hold-off when asked.
   always @(negedge clock) begin
      if (stall_request > 0) begin
         rsp_ch.ready = 1'b0;
         stall_request = stall_request - 1;
      end else if (jitter_on) begin
         rsp_ch.ready = ($urandom_range(99) >= 27);
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // Event checker: each accepted event against the oldest expectation.
   always @(posedge clock) begin
      button_event_type exp_e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected event: kind %0d button %0d pattern %h last %0b",
                        rsp_ch.event_kind, rsp_ch.button, rsp_ch.stable_buttons,
                        rsp_ch.last);
         end else begin
            exp_e = expected_events.pop_front();
            if (rsp_ch.event_kind !== exp_e.kind || rsp_ch.button !== exp_e.button ||
                rsp_ch.stable_buttons !== exp_e.pattern || rsp_ch.last !== exp_e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Event mismatch: expected %0d/%0d/%h/%0b, got %0d/%0d/%h/%0b",
                           exp_e.kind, exp_e.button, exp_e.pattern, exp_e.last,
                           rsp_ch.event_kind, rsp_ch.button, rsp_ch.stable_buttons,
                           rsp_ch.last);
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= 20000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Defaults after reset: active-low pins, a press, a cancelled release,
   // a committed release, and every button at once.
   task automatic test_reset_defaults();
      poll_after(0, 16'h0000);
      poll_after(10, 16'h0001);
      poll_after(50, 16'h0001);       // exactly debounce_ms later: commits
      poll_after(10, 16'h0000);       // release starts pending
      poll_after(10, 16'h0001);       // back to stable cancels it
      poll_after(45, 16'h0000);
      poll_after(49, 16'h0000);       // one short of the debounce time
      poll_after(1, 16'h0000);
      poll_after(5, 16'hFFFF);
      poll_after(60, 16'hFFFF);
      poll_after(60, 16'h0000);
      poll_after(60, 16'h0000);
      wait_idle();
   endtask

   // Active-high pins with some buttons inverted, and a zero debounce time,
   // so each change commits in the poll that shows it.
   task automatic test_polarity();
      write_reg(CSR_ACTIVE_LEVEL, 16'd1);
      write_reg(CSR_INVERT_MASK, 16'hA5A5);
      write_reg(CSR_DEBOUNCE_MS, 16'd0);
      poll_after(1, 16'h00FF);
      poll_after(1, 16'h0000);
      poll_after(1, 16'hFFFF);
      poll_after(1, 16'h0000);
      wait_idle();
   endtask

   // Selectors, auto-repeat with a zero period (repeat in the press poll)
   // and all-selectors-off.
   task automatic test_selectors_repeat();
      write_reg(CSR_SELECTOR_MASK, 16'hF000);
      write_reg(CSR_REPEAT_MASK, 16'h000F);
      write_reg(CSR_REPEAT_MS, 16'd0);
      poll_after(3, 16'hF003);
      poll_after(3, 16'h3003);
      poll_after(3, 16'h0001);
      wait_idle();
      write_reg(CSR_REPEAT_MS, 16'd100);
      poll_after(3, 16'h0002);
      poll_after(99, 16'h0002);
      poll_after(1, 16'h0002);
      poll_after(300, 16'h0000);
      wait_idle();
   endtask

   // Button count of zero, saturated and partial; poll interval with the
   // time base wrapping through zero.
   task automatic test_count_and_interval();
      write_reg(CSR_BUTTON_COUNT, 16'd0);
      poll_after(1, 16'hFFFF);
      wait_idle();
      write_reg(CSR_BUTTON_COUNT, 16'd31);
      poll_after(1, 16'hFFFF);
      wait_idle();
      write_reg(CSR_BUTTON_COUNT, 16'd3);
      poll_after(1, 16'h0000);        // high bits stay in the pattern
      wait_idle();
      write_reg(CSR_POLL_INTERVAL, 16'd200);
      clock_ms = 32'hFFFF_FF80;
      poll_after(0, 16'h0007);
      poll_after(100, 16'h0000);      // too soon: ignored
      poll_after(100, 16'h0000);
      wait_idle();
      write_reg(CSR_POLL_INTERVAL, 16'hFFFF);
      poll_after(32'h0000_FFFE, 16'h0005);
      poll_after(1, 16'h0005);
      wait_idle();
   endtask

   // Random phases: each writes a fresh configuration, then plays held
   // patterns with glitches, mostly well formed, some pure noise.
   task automatic test_random();
      logic [15:0] held, glitch;
      int n_items, hold_len;
      n_items = 0;
      for (int phase = 0; phase < 7; phase++) begin
         jitter_on = (phase != 3);
         write_reg(CSR_ACTIVE_LEVEL, 16'($urandom_range(1)));
         write_reg(CSR_INVERT_MASK, (phase == 0) ? 16'hFFFF : 16'($urandom));
         write_reg(CSR_SELECTOR_MASK,
                   (phase == 6) ? 16'hFFFF : 16'($urandom & $urandom));
         write_reg(CSR_REPEAT_MASK, (phase == 1) ? 16'hFFFF : 16'($urandom));
         write_reg(CSR_BUTTON_COUNT,
                   (phase == 2) ? 16'd1 : 16'($urandom_range(1, 20)));
         write_reg(CSR_DEBOUNCE_MS,
                   (phase == 5) ? 16'hFFFF : 16'($urandom_range(0, 40)));
         write_reg(CSR_REPEAT_MS,
                   (phase == 4) ? 16'hFFFF : 16'($urandom_range(0, 60)));
         write_reg(CSR_POLL_INTERVAL,
                   (phase == 5) ? 16'd0 : 16'($urandom_range(0, 6)));
         clock_ms = $urandom;
         for (int k = 0; k < 8; k++) begin
            held = 16'($urandom);
            hold_len = $urandom_range(1, 6);
            for (int j = 0; j < hold_len; j++) begin
               glitch = ($urandom_range(3) == 0) ? 16'd1 << $urandom_range(15) : 16'd0;
               if ($urandom_range(9) == 0)
                  clock_ms += (phase == 5) ? $urandom_range(30000, 70000) : $urandom;
               if ($urandom_range(9) == 0)
                  send_poll(16'($urandom), 32'(clock_ms + $urandom_range(0, 30)));
               else
                  poll_after(32'($urandom_range(0, 25)), held ^ glitch);
               n_items++;
            end
         end
         wait_idle();
      end
      jitter_on = 1;
   endtask

   // Long receiver hold-off while polls that toggle all sixteen buttons keep
   // coming, so the block fills and stalls its input.
   task automatic test_backpressure();
      write_reg(CSR_SELECTOR_MASK, 16'h0000);
      write_reg(CSR_REPEAT_MASK, 16'h0000);
      write_reg(CSR_BUTTON_COUNT, 16'd16);
      write_reg(CSR_DEBOUNCE_MS, 16'd0);
      write_reg(CSR_POLL_INTERVAL, 16'd0);
      stall_request = 600;
      for (int k = 0; k < 6; k++) poll_after(1, (k % 2 == 0) ? 16'hFFFF : 16'h0000);
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_ACTIVE_LEVEL;
      csr_wdata = 16'd0;
      req_ch.valid = 1'b0;
      req_ch.pin_levels = 16'd0;
      req_ch.time_ms = 32'd0;
      rsp_ch.ready = 1'b0;
      cfg_active = 1'b0;
      cfg_invert = 16'd0;
      cfg_selector = 16'd0;
      cfg_repeat = 16'd0;
      cfg_count = 5'd16;
      cfg_debounce = 16'd50;
      cfg_repeat_ms = 16'd200;
      cfg_interval = 16'd0;
      stable_q = 16'd0;
      pending_q = 16'd0;
      target_q = 16'd0;
      held_q = 16'd0;
      sel_seen_q = 16'd0;
      last_poll_q = 32'd0;
      foreach (change_at[i]) begin
         change_at[i] = 32'd0;
         repeat_at[i] = 32'd0;
      end
      repeat (8) @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      test_reset_defaults();
      test_polarity();
      test_selectors_repeat();
      test_count_and_interval();
      test_random();
      test_backpressure();

      if (mismatches == 0 && expected_events.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
